/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, suspended while reset is held.
`define VDIB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, also during reset.
`define VDIB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/vdib_pkg.sv */
`default_nettype none

package vdib_pkg;

    localparam int COORD_W  = 16;
    localparam int TRIPLE_W = 3 * COORD_W;
    localparam int UV_W     = 64;
    localparam int BUDGET_W = 9;
    localparam int INDEX_W  = 8;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 9'd256;

    // One stored table entry.
    typedef struct packed {
        logic [TRIPLE_W-1:0] pos;
        logic [TRIPLE_W-1:0] nrm;
        logic [UV_W-1:0]     uv;
    } vertex_entry_t;

    // Search key broadcast along the cell row (uv already zeroed if untextured).
    typedef struct packed {
        vertex_entry_t entry;
        logic          textured;
    } vertex_key_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic start;    // park the probe token in the head cell
        logic advance;  // move the probe token one cell on
        logic append;   // cell holding the token stores the key
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SCAN
    } scan_state_t;

endpackage

`default_nettype wire

/* rtl/vertex_dedup_index_builder_unit.sv */
// Channel   Signals                              Direction  Moves
// --------  -----------------------------------  ---------  ---------------------------
// in        in_valid / in_ready + key fields     sink       one vertex key per transfer
// out       out_valid / out_ready + result       source     one result per transfer
// cfg       cfg_we / cfg_wdata                   sink       vertex budget, no wait
//
// The search for an item stops at the hit index, or at the entry count on a miss,
// and at once when the overflow fault is set.
// The probe token walks the cell row one cell per cycle from cell 0.
// One item is in flight at a time; the next is taken once the result is registered.
// A stalled output holds the search at its final step until the register frees.
// Reset (rst_n, async) empties the table, clears the fault and sets budget to 256.
`default_nettype none
`include "assert_macros.svh"

module vertex_dedup_index_builder_unit
    import vdib_pkg::*;
#(
    parameter int MAX_VERTICES = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [BUDGET_W-1:0]   cfg_wdata,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [15:0]    pos_x,
    input  wire logic signed [15:0]    pos_y,
    input  wire logic signed [15:0]    pos_z,
    input  wire logic signed [15:0]    nrm_x,
    input  wire logic signed [15:0]    nrm_y,
    input  wire logic signed [15:0]    nrm_z,
    input  wire logic [31:0]           uv_u_key,
    input  wire logic [31:0]           uv_v_key,
    input  wire logic                  is_textured,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [INDEX_W-1:0]         vertex_index,
    output logic                       was_appended,
    output logic                       status
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > BUDGET_W) ? CNT_W : BUDGET_W;
    localparam int IDX_X = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    scan_state_t          state_reg, state_next;
    vertex_key_t          key_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;     // entries held
    logic [CNT_W-1:0]     scan_reg, scan_next;   // position of the probe token
    logic                 fault_reg, fault_next; // sticky overflow
    logic [BUDGET_W-1:0]  budget_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]   out_index_reg, out_index_next;
    logic                 out_app_reg, out_app_next;
    logic                 out_status_reg, out_status_next;

    cell_ctl_t            ctl;
    logic [MAX_VERTICES-1:0] token_vec;
    logic [MAX_VERTICES-1:0] hit_vec;

    logic                 in_xfer;
    logic                 slot_free;
    logic                 any_hit;
    logic                 at_end;
    logic                 full;
    logic                 done;
    logic                 overflow;
    logic [CMP_W-1:0]     budget_w;
    logic [CMP_W-1:0]     max_w;
    logic [CMP_W-1:0]     limit_w;
    logic [IDX_X-1:0]     scan_x;

    // ---------------------------------------------------------------
    // Cell row: each cell holds one table entry and one probe token bit
    // ---------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++)
        begin : g_cell
            logic tok_prev;
            if (g == 0)
            begin : g_head
                assign tok_prev = 1'b0;
            end
            else
            begin : g_body
                assign tok_prev = token_vec[g-1];
            end

            vdib_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .head      ((g == 0) ? 1'b1 : 1'b0),
                .token_in  (tok_prev),
                .ctl       (ctl),
                .key       (key_reg),
                .token_out (token_vec[g]),
                .hit       (hit_vec[g])
            );
        end
    endgenerate

    assign any_hit = |hit_vec;

    // ---------------------------------------------------------------
    // Decision terms
    // ---------------------------------------------------------------
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign at_end    = (scan_reg == cnt_reg);

    // effective budget is clamped to the row length
    assign budget_w = CMP_W'(budget_reg);
    assign max_w    = CMP_W'(MAX_VERTICES);
    assign limit_w  = (budget_w > max_w) ? max_w : budget_w;
    assign full     = (CMP_W'(cnt_reg) >= limit_w);

    // search ends on a fault, on a hit, or when the token reaches the free slot;
    // the free-slot test comes first so unwritten cells are never trusted
    assign done     = (state_reg == ST_SCAN) && slot_free &&
                      (fault_reg || at_end || any_hit);
    assign overflow = fault_reg || at_end && full;

    assign scan_x   = IDX_X'(scan_reg);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // State outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready    = 1'b0;
        ctl.start   = 1'b0;
        ctl.advance = 1'b0;
        ctl.append  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_MATCH:
            begin
                // match flags settle this cycle; token parks in cell 0
                ctl.start = 1'b1;
            end
            ST_SCAN:
            begin
                ctl.advance = !fault_reg && !at_end && !any_hit;
                ctl.append  = done && !overflow && at_end;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Counters, fault and result register
    // ---------------------------------------------------------------
    always_comb
    begin
        scan_next = scan_reg;
        if (ctl.start)
        begin
            scan_next = '0;
        end
        else if (ctl.advance)
        begin
            scan_next = scan_reg + 1'b1;
        end
    end

    assign cnt_next   = ctl.append ? (cnt_reg + 1'b1) : cnt_reg;
    assign fault_next = fault_reg || (done && overflow);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_app_next    = out_app_reg;
        out_status_next = out_status_reg;
        if (done)
        begin
            out_valid_next  = 1'b1;
            out_index_next  = overflow ? '0 : scan_x[INDEX_W-1:0];
            out_app_next    = ctl.append;
            out_status_next = overflow;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            fault_reg     <= 1'b0;
            budget_reg    <= BUDGET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_index_reg  <= out_index_next;
        out_app_reg    <= out_app_next;
        out_status_reg <= out_status_next;
        if (in_xfer)
        begin
            key_reg.entry.pos <= {pos_x, pos_y, pos_z};
            key_reg.entry.nrm <= {nrm_x, nrm_y, nrm_z};
            key_reg.entry.uv  <= is_textured ? {uv_u_key, uv_v_key} : '0;
            key_reg.textured  <= is_textured;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_index_reg;
    assign was_appended = out_app_reg;
    assign status       = out_status_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `VDIB_ASSERT(a_one_token, clk, rst_n, $onehot0(token_vec), "more than one probe token")
    `VDIB_ASSERT(a_cnt_bound, clk, rst_n, CMP_W'(cnt_reg) <= max_w, "entry count past row length")
    `VDIB_ASSERT(a_fault_sticky, clk, rst_n, fault_reg |=> fault_reg, "overflow fault cleared")
    `VDIB_ASSERT(a_append_step, clk, rst_n, ctl.append |=> (cnt_reg == $past(cnt_reg) + 1'b1), "append did not bump count")
    `VDIB_ASSERT(a_scan_bound, clk, rst_n, (state_reg == ST_SCAN) |-> (scan_reg <= cnt_reg), "probe passed the free slot")

endmodule

`default_nettype wire

/* rtl/vdib_cell.sv */
`default_nettype none

module vdib_cell
    import vdib_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head,
    input  wire logic        token_in,
    input  wire cell_ctl_t   ctl,
    input  wire vertex_key_t key,
    output logic             token_out,
    output logic             hit
);

    logic          token_reg;
    logic          token_next;
    logic          match_reg;
    logic          match_next;
    vertex_entry_t entry_reg;

    always_comb
    begin
        if (ctl.start)
        begin
            token_next = head;
        end
        else if (ctl.advance)
        begin
            token_next = token_in;
        end
        else
        begin
            token_next = token_reg;
        end
    end

    // uv only counts for a textured key
    assign match_next = (entry_reg.pos == key.entry.pos) &&
                        (entry_reg.nrm == key.entry.nrm) &&
                        (!key.textured || (entry_reg.uv == key.entry.uv));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= 1'b0;
        end
        else
        begin
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        if (ctl.append && token_reg)
        begin
            entry_reg <= key.entry;
        end
    end

    assign token_out = token_reg;
    assign hit       = token_reg & match_reg;

endmodule

`default_nettype wire

/* bench/tb_vertex_dedup_index_builder_unit.sv */
`timescale 1ns / 1ps

module tb_vertex_dedup_index_builder_unit
    import vdib_pkg::*;
();

    localparam int TABLE_DEPTH = 256;
    // Receiver hold-off: starts once this many input transfers have gone through.
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 300;
    // Tail after the last result.
    localparam int TAIL_CYCLES = 300;

    // One vertex key as it is offered on the input channel.
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] nrm_x;
        logic signed [COORD_W-1:0] nrm_y;
        logic signed [COORD_W-1:0] nrm_z;
        logic [31:0]               uv_u;
        logic [31:0]               uv_v;
        logic                      textured;
    } vertex_t;

    // One result as it leaves the output channel.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               appended;
        logic               status;
    } lookup_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [BUDGET_W-1:0] cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    vertex_t             cur = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [INDEX_W-1:0]  vertex_index;
    logic                was_appended;
    logic                status;

    vertex_dedup_index_builder_unit #(
        .MAX_VERTICES (TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pos_x        (cur.pos_x),
        .pos_y        (cur.pos_y),
        .pos_z        (cur.pos_z),
        .nrm_x        (cur.nrm_x),
        .nrm_y        (cur.nrm_y),
        .nrm_z        (cur.nrm_z),
        .uv_u_key     (cur.uv_u),
        .uv_v_key     (cur.uv_v),
        .is_textured  (cur.textured),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .was_appended (was_appended),
        .status       (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Vertex table mirror: the bench's own copy of the block's state.
    // ------------------------------------------------------------------
    vertex_entry_t       vtable [TABLE_DEPTH];
    int                  vtable_fill = 0;
    logic                budget_fault = 1'b0;
    logic [BUDGET_W-1:0] budget_now = BUDGET_RESET;

    // Lowest-index match on position and normal (UV too when textured),
    // else append if under budget, else raise the sticky fault.
    function automatic lookup_t resolve_vertex(input vertex_t v);
        lookup_t       r;
        vertex_entry_t probe;
        int            cap;
        probe.pos = {v.pos_x, v.pos_y, v.pos_z};
        probe.nrm = {v.nrm_x, v.nrm_y, v.nrm_z};
        probe.uv  = v.textured ? {v.uv_u, v.uv_v} : '0;
        r = '{index: '0, appended: 1'b0, status: 1'b1};
        if (budget_fault)
            return r;
        for (int i = 0; i < vtable_fill; i++)
        begin
            if (vtable[i].pos == probe.pos && vtable[i].nrm == probe.nrm &&
                (!v.textured || vtable[i].uv == probe.uv))
            begin
                r.index  = i[INDEX_W-1:0];
                r.status = 1'b0;
                return r;
            end
        end
        // budgets past the table size behave as a full table
        cap = (budget_now > TABLE_DEPTH) ? TABLE_DEPTH : budget_now;
        if (vtable_fill >= cap)
        begin
            budget_fault = 1'b1;
            return r;
        end
        vtable[vtable_fill] = probe;
        r.index    = vtable_fill[INDEX_W-1:0];
        r.appended = 1'b1;
        r.status   = 1'b0;
        vtable_fill++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Queues shared by generator, driver and monitor.
    // ------------------------------------------------------------------
    vertex_t vertex_backlog[$];   // keys waiting to be offered
    lookup_t index_forecast[$];   // predicted results, oldest first
    int      errors = 0;
    int      transfers_in = 0;
    int      send_odds = 0;       // 1-in-N chance of a sender gap per free slot; 0 = never
    int      recv_odds = 0;       // same for receiver stalls

    // ------------------------------------------------------------------
    // Driver: offers backlog keys; the payload is only changed once the
    // previous transfer has gone through.
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                // cur still holds the transferred key here
                index_forecast = {index_forecast, resolve_vertex(cur)};
                transfers_in <= transfers_in + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (vertex_backlog.size() != 0 && send_odds != 0 &&
                         $urandom_range(1, send_odds) == 1)
                begin
                    gap_left <= $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end
                else if (vertex_backlog.size() != 0)
                begin
                    cur      <= vertex_backlog.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, so the block backs up and drops in_ready
    // while the driver keeps offering.
    // ------------------------------------------------------------------
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic holding;

    assign holding = (hold_left != 0);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && transfers_in >= HOLD_AT)
            begin
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every output transfer against the oldest forecast,
    // and drives out_ready with random stall bursts.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (index_forecast.size() == 0)
                begin
                    $display("%0t: unexpected result: index %0d appended %0b status %0b",
                             $time, vertex_index, was_appended, status);
                    errors++;
                end
                else
                begin
                    want = index_forecast.pop_front();
                    if (vertex_index !== want.index)
                    begin
                        $display("%0t: vertex_index expected %0d, got %0d",
                                 $time, want.index, vertex_index);
                        errors++;
                    end
                    if (was_appended !== want.appended)
                    begin
                        $display("%0t: was_appended expected %0b, got %0b",
                                 $time, want.appended, was_appended);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0b, got %0b",
                                 $time, want.status, status);
                        errors++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1)
            begin
                stall_left <= $urandom_range(0, 10);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= !holding;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation.
    // known keeps every key already queued: before the fault, an exact
    // repeat (or an untextured copy) of one of them is a certain hit.
    // append_bound counts keys that may append, an upper bound on the
    // table fill, so the budget is never hit before the last phase.
    // ------------------------------------------------------------------
    vertex_t known[$];
    int      append_bound = 0;

    task automatic queue_item(input vertex_t v, input logic may_append);
        vertex_backlog = {vertex_backlog, v};
        known          = {known, v};
        if (may_append)
            append_bound++;
    endtask

    function automatic vertex_t random_vertex();
        vertex_t v;
        v.pos_x    = COORD_W'($urandom);
        v.pos_y    = COORD_W'($urandom);
        v.pos_z    = COORD_W'($urandom);
        v.nrm_x    = COORD_W'($urandom);
        v.nrm_y    = COORD_W'($urandom);
        v.nrm_z    = COORD_W'($urandom);
        v.uv_u     = $urandom;
        v.uv_v     = $urandom;
        v.textured = 1'($urandom_range(0, 1));
        return v;
    endfunction

    // Stored key, sometimes untextured with junk UV: still a hit.
    function automatic vertex_t reuse_vertex();
        vertex_t v;
        v = known[$urandom_range(0, known.size() - 1)];
        if ($urandom_range(0, 3) == 0)
        begin
            v.textured = 1'b0;
            v.uv_u     = $urandom;
            v.uv_v     = $urandom;
        end
        return v;
    endfunction

    // Near miss: one bit flipped in a field that takes part in the compare.
    // Packed layout: textured at bit 0, UV keys at 64:1, position/normal at 160:65.
    function automatic vertex_t nudge_vertex(input vertex_t v);
        int b;
        b = v.textured ? 1 + $urandom_range(0, 159) : 65 + $urandom_range(0, 95);
        v[b] = ~v[b];
        return v;
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 3;
            2: return 8;
            default: return 20;
        endcase
    endfunction

    // Wait until every queued key has been transferred and every result seen.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (vertex_backlog.size() != 0 || in_valid || index_forecast.size() != 0);
    endtask

    // Budget writes only happen with the block idle.
    task automatic begin_phase(input logic [BUDGET_W-1:0] budget, input int s_odds,
                               input int r_odds);
        wait_drained();
        send_odds = s_odds;
        recv_odds = r_odds;
        repeat (4) @(posedge clk);
        cfg_wdata <= budget;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        budget_now = budget;
    endtask

    initial
    begin
        vertex_t lo, hi, zr, alt, w;
        int      lim;
        int      pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_odds = 4;
        recv_odds = 4;

        // Reset budget: one textured key appended at index 0.
        w = random_vertex();
        w.textured = 1'b1;
        queue_item(w, 1'b1);

        // Budget of one with one entry stored: only hits, no overflow.
        begin_phase(9'd1, 5, 5);
        repeat (5) queue_item(reuse_vertex(), 1'b0);

        // Budget of zero, below the fill: stored entries still hit.
        begin_phase(9'd0, 2, 2);
        repeat (5) queue_item(reuse_vertex(), 1'b0);

        // Directed keys at full budget.
        begin_phase(9'd256, 3, 3);
        lo  = {{6{16'h8000}}, 64'h0, 1'b0};
        hi  = {{6{16'h7fff}}, {2{32'hffff_ffff}}, 1'b1};
        zr  = '0;
        alt = {{3{16'h5555}}, {3{16'haaaa}}, 32'haaaa_aaaa, 32'h5555_5555, 1'b1};
        queue_item(lo, 1'b1);
        queue_item(hi, 1'b1);
        queue_item(zr, 1'b1);
        queue_item(hi, 1'b0);                 // exact repeat
        w = hi;
        w.textured = 1'b0;
        queue_item(w, 1'b0);                  // untextured: UV ignored
        w = hi;
        w.uv_u = 32'hffff_fffe;
        queue_item(w, 1'b1);                  // u key differs
        w = hi;
        w.uv_v = 32'h7fff_ffff;
        queue_item(w, 1'b1);                  // v key differs
        queue_item(w, 1'b0);                  // hits the entry just made
        w = lo;
        w.textured = 1'b1;
        queue_item(w, 1'b0);                  // textured zero UV hits untextured entry
        w.uv_v = 32'h1;
        queue_item(w, 1'b1);                  // nonzero UV misses it
        w.textured = 1'b0;
        queue_item(w, 1'b0);                  // two candidates: lowest index wins
        w = lo;
        w.pos_z = 16'sh8001;
        queue_item(w, 1'b1);
        w = lo;
        w.nrm_x = 16'sh7fff;
        queue_item(w, 1'b1);
        queue_item(alt, 1'b1);
        queue_item(~alt, 1'b1);
        w = zr;
        w.uv_u = 32'h1234_5678;
        queue_item(w, 1'b0);                  // untextured zero key, junk UV

        // Random phases: mostly hits on stored keys, some near misses and
        // fresh keys, budget kept above the possible fill.
        for (int ph = 0; ph < 4; ph++)
        begin
            lim = append_bound + $urandom_range(10, 60);
            if (lim > TABLE_DEPTH)
                lim = TABLE_DEPTH;
            begin_phase(lim[BUDGET_W-1:0], pick_odds(), pick_odds());
            repeat (220)
            begin
                pick = $urandom_range(0, 99);
                if (append_bound < lim && pick < 12)
                    queue_item(random_vertex(), 1'b1);
                else if (append_bound < lim && pick < 35)
                    queue_item(nudge_vertex(known[$urandom_range(0, known.size() - 1)]),
                               1'b1);
                else
                    queue_item(reuse_vertex(), 1'b0);
            end
        end

        // Last part, no idling: budget above the table size acts as a full
        // table; fill it, overflow, then every key reports overflow.
        begin_phase(9'h1ff, 0, 0);
        while (append_bound < TABLE_DEPTH + 3)
            queue_item(random_vertex(), 1'b1);
        repeat (20) queue_item(reuse_vertex(), 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
